FILE: rtl/keyed_table_pinned_round_robin_core_defines.svh
// Assertion macros used by the table core RTL file.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef KEYED_TABLE_PINNED_ROUND_ROBIN_CORE_DEFINES_SVH
`define KEYED_TABLE_PINNED_ROUND_ROBIN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KTRR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ktrr: same-cycle check failed");
// Next-cycle implication
`define KTRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ktrr: next-cycle check failed");
`else
`define KTRR_ASSERT_IMPLY(label, ante, cons)
`define KTRR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/ktrr_pkg.sv
package ktrr_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int SLOTS   = 4;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int RATING_W = 24;
    localparam int RANK_W   = 8;
    localparam int MODE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int SLOTIN_W = 3;
    localparam int CFG_IDX_W = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_READ_A       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_READ_B       = 4'd1;
    localparam logic [MODE_W-1:0] MODE_READ_RANK    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE_A      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE_B      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_WRITE_RANK   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BIND         = 4'd6;
    localparam logic [MODE_W-1:0] MODE_KEY_WRITE_A  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_KEY_WRITE_B  = 4'd8;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_KEY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 2'd3;

    // Configuration reset values
    localparam logic [RATING_W-1:0] FLOOR_RST   = 24'd0;
    localparam logic [RATING_W-1:0] CEILING_RST = 24'hFFFFFF;
    localparam logic [RATING_W-1:0] DEFAULT_RST = 24'd1280000;
    localparam logic [RANK_W-1:0]   RANK_RST    = 8'd15;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_RANK
    } wr_sel_t;

    // One profile entry
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic                has_data;
        logic [RATING_W-1:0] rating_a;
        logic [RATING_W-1:0] rating_b;
        logic [RANK_W-1:0]   rank;
    } entry_t;

    // Entry write request from the sequencer
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic                clear;
        logic [KEY_W-1:0]    key;
        wr_sel_t             sel;
        logic [RATING_W-1:0] rating;
        logic [RANK_W-1:0]   rank;
    } wr_req_t;

    // Compare results for the entry under scan
    typedef struct packed {
        logic hit;
        logic free;
        logic bound;
    } scan_res_t;

    // Positive as a signed 32-bit value
    function automatic logic key_usable(input logic [KEY_W-1:0] k);
        return (k != '0) && !k[KEY_W-1];
    endfunction

endpackage

FILE: rtl/keyed_table_pinned_round_robin_core.sv
// Keyed profile table with slot bindings and round-robin replacement.
// Request channel s_*: one beat per request. s_tuser carries the mode,
// s_tdata the slot, keys, rating and rank. Result channel m_*: one beat per
// request, rating_out and rank_out in m_tdata, status in m_tuser.
// Configuration: cfg_we with cfg_index/cfg_data writes one register per
// clock; write only while no request is in flight.
// Sequence: reads, binds and requests without a usable key go from resolve
// straight to the result; a read with a usable key first scans every entry.
// Writes scan, then write a hit or free entry, or walk the table for an
// eviction when neither is found: the entry scan and the eviction walk
// each examine one entry per cycle through the single compare unit.
// Throughput: one request at a time, s_tready is high only while idle; the
// next request is taken no earlier than the edge at which the previous
// result beat can first be taken.
// Stall: a finished result sits in the output register until m_tready;
// the next request is accepted meanwhile, but its result waits until the
// register frees up.
// Reset: all entries empty, bindings and eviction pointer zero, registers
// at their reset values. No clearing pass is needed.
`include "keyed_table_pinned_round_robin_core_defines.svh"

module keyed_table_pinned_round_robin_core (
    input  logic         clk,
    input  logic         rst_n,
    // request beat
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] slot_index, [34:3] live_key, [66:35] direct_key,
    // [90:67] rating_in, [98:91] rank_in, [103:99] zero
    input  logic [103:0] s_tdata,
    // [3:0] mode
    input  logic [3:0]   s_tuser,
    // result beat
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] rating_out, [31:24] rank_out
    output logic [31:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int IW = ktrr_pkg::IDX_W;
    localparam int KW = ktrr_pkg::KEY_W;
    localparam int RW = ktrr_pkg::RATING_W;
    localparam int NW = ktrr_pkg::RANK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ktrr_pkg::ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_SCAN,
        ST_DECIDE,
        ST_EVICT,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Configuration
    logic [RW-1:0] floor_reg;
    logic [RW-1:0] ceiling_reg;
    logic [RW-1:0] default_reg;
    logic [NW-1:0] rank_limit_reg;

    // Request fields
    logic [ktrr_pkg::MODE_W-1:0]   mode_reg;
    logic [ktrr_pkg::SLOTIN_W-1:0] slot_reg;
    logic [KW-1:0] live_reg;
    logic [KW-1:0] direct_reg;
    logic [RW-1:0] rating_in_reg;
    logic [NW-1:0] rank_in_reg;

    // Table control state
    logic [ktrr_pkg::SLOTS-1:0][KW-1:0] bound_key_reg;
    logic [IW-1:0] evict_ptr_reg;
    logic [IW-1:0] scan_idx_reg;
    logic [IW-1:0] evict_cnt_reg;
    logic [KW-1:0] target_key_reg;
    logic          hit_found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [RW-1:0] cap_a_reg;
    logic [RW-1:0] cap_b_reg;
    logic [NW-1:0] cap_rank_reg;
    logic [IW-1:0] tgt_idx_reg;
    logic          tgt_clear_reg;

    // Result
    logic [RW-1:0] res_rating_reg;
    logic [NW-1:0] res_rank_reg;
    logic [ktrr_pkg::STATUS_W-1:0] res_status_reg;
    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    ktrr_pkg::entry_t    rd_entry;
    ktrr_pkg::scan_res_t scan_res;
    ktrr_pkg::wr_req_t   wr_req;
    logic [IW-1:0]       rd_idx;

    logic                        slot_ok;
    logic [ktrr_pkg::SLOT_W-1:0] sidx;
    logic [KW-1:0]               slot_bound;
    logic                        is_read;
    logic                        is_write;
    logic [RW-1:0]               rating_floored;
    logic [RW-1:0]               rating_clamped;
    logic                        out_load;
    logic                        accept;

    ktrr_entry_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr_req),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    ktrr_scan_unit u_scan (
        .entry      (rd_entry),
        .target_key (target_key_reg),
        .bound_key  (bound_key_reg),
        .res        (scan_res)
    );

    // Request decode
    assign slot_ok    = {1'b0, slot_reg} < 4'(ktrr_pkg::SLOTS);
    assign sidx       = slot_reg[ktrr_pkg::SLOT_W-1:0];
    assign slot_bound = bound_key_reg[sidx];
    assign is_read    = mode_reg <= ktrr_pkg::MODE_READ_RANK;
    assign is_write   = ((mode_reg >= ktrr_pkg::MODE_WRITE_A)
                         && (mode_reg <= ktrr_pkg::MODE_WRITE_RANK))
                        || (mode_reg == ktrr_pkg::MODE_KEY_WRITE_A)
                        || (mode_reg == ktrr_pkg::MODE_KEY_WRITE_B);

    // Rating clamp: floor first, ceiling wins
    assign rating_floored = (rating_in_reg < floor_reg) ? floor_reg : rating_in_reg;
    assign rating_clamped = (rating_floored > ceiling_reg) ? ceiling_reg : rating_floored;

    // Scan address
    assign rd_idx = (state_reg == ST_EVICT) ? evict_ptr_reg : scan_idx_reg;

    // Entry write request
    always_comb
    begin
        wr_req.en     = (state_reg == ST_WRITE);
        wr_req.idx    = tgt_idx_reg;
        wr_req.clear  = tgt_clear_reg;
        wr_req.key    = target_key_reg;
        wr_req.rating = rating_clamped;
        wr_req.rank   = (rank_in_reg <= rank_limit_reg) ? rank_in_reg : rank_limit_reg;
        case (mode_reg)
            ktrr_pkg::MODE_WRITE_B, ktrr_pkg::MODE_KEY_WRITE_B: wr_req.sel = ktrr_pkg::SEL_B;
            ktrr_pkg::MODE_WRITE_RANK:                          wr_req.sel = ktrr_pkg::SEL_RANK;
            default:                                            wr_req.sel = ktrr_pkg::SEL_A;
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer, table control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            floor_reg      <= ktrr_pkg::FLOOR_RST;
            ceiling_reg    <= ktrr_pkg::CEILING_RST;
            default_reg    <= ktrr_pkg::DEFAULT_RST;
            rank_limit_reg <= ktrr_pkg::RANK_RST;
            mode_reg       <= '0;
            slot_reg       <= '0;
            live_reg       <= '0;
            direct_reg     <= '0;
            rating_in_reg  <= '0;
            rank_in_reg    <= '0;
            bound_key_reg  <= '0;
            evict_ptr_reg  <= '0;
            scan_idx_reg   <= '0;
            evict_cnt_reg  <= '0;
            target_key_reg <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            cap_a_reg      <= '0;
            cap_b_reg      <= '0;
            cap_rank_reg   <= '0;
            tgt_idx_reg    <= '0;
            tgt_clear_reg  <= 1'b0;
            res_rating_reg <= '0;
            res_rank_reg   <= '0;
            res_status_reg <= ktrr_pkg::STATUS_DONE;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ktrr_pkg::CFG_FLOOR:   floor_reg      <= cfg_data;
                    ktrr_pkg::CFG_CEILING: ceiling_reg    <= cfg_data;
                    ktrr_pkg::CFG_DEFAULT: default_reg    <= cfg_data;
                    ktrr_pkg::CFG_RANK:    rank_limit_reg <= cfg_data[NW-1:0];
                    default: ;
                endcase
            end

            // result beat taken
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg       <= s_tuser;
                        slot_reg       <= s_tdata[2:0];
                        live_reg       <= s_tdata[34:3];
                        direct_reg     <= s_tdata[66:35];
                        rating_in_reg  <= s_tdata[90:67];
                        rank_in_reg    <= s_tdata[98:91];
                        res_rating_reg <= '0;
                        res_rank_reg   <= '0;
                        res_status_reg <= ktrr_pkg::STATUS_DONE;
                        state_reg      <= ST_RESOLVE;
                    end
                end

                ST_RESOLVE:
                begin
                    scan_idx_reg   <= '0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    if (mode_reg == ktrr_pkg::MODE_BIND)
                    begin
                        if (slot_ok && ktrr_pkg::key_usable(direct_reg))
                        begin
                            bound_key_reg[sidx] <= direct_reg;
                        end
                        else
                        begin
                            res_status_reg <= ktrr_pkg::STATUS_NO_KEY;
                        end
                        state_reg <= ST_DONE;
                    end
                    else if (is_read || is_write)
                    begin
                        logic [KW-1:0] key;
                        key = direct_reg;
                        if (mode_reg <= ktrr_pkg::MODE_WRITE_RANK)
                        begin
                            if (!slot_ok)
                            begin
                                key = '0;
                            end
                            else if (ktrr_pkg::key_usable(live_reg))
                            begin
                                bound_key_reg[sidx] <= live_reg;
                                key = live_reg;
                            end
                            else if (ktrr_pkg::key_usable(slot_bound))
                            begin
                                key = slot_bound;
                            end
                            else
                            begin
                                key = '0;
                            end
                        end
                        target_key_reg <= key;
                        if (ktrr_pkg::key_usable(key))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            res_status_reg <= ktrr_pkg::STATUS_NO_KEY;
                            if (mode_reg == ktrr_pkg::MODE_READ_A
                                || mode_reg == ktrr_pkg::MODE_READ_B)
                            begin
                                res_rating_reg <= default_reg;
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                // one entry per cycle: first match and first free entry
                ST_SCAN:
                begin
                    if (scan_res.hit && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= scan_idx_reg;
                        cap_a_reg     <= rd_entry.rating_a;
                        cap_b_reg     <= rd_entry.rating_b;
                        cap_rank_reg  <= rd_entry.rank;
                    end
                    if (scan_res.free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_idx_reg;
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                ST_DECIDE:
                begin
                    if (is_read)
                    begin
                        if (mode_reg == ktrr_pkg::MODE_READ_A)
                        begin
                            res_rating_reg <= hit_found_reg ? cap_a_reg : default_reg;
                        end
                        else if (mode_reg == ktrr_pkg::MODE_READ_B)
                        begin
                            res_rating_reg <= hit_found_reg ? cap_b_reg : default_reg;
                        end
                        else
                        begin
                            res_rank_reg <= (hit_found_reg && cap_rank_reg <= rank_limit_reg)
                                            ? cap_rank_reg : '0;
                        end
                        state_reg <= ST_DONE;
                    end
                    else if (hit_found_reg)
                    begin
                        tgt_idx_reg   <= hit_idx_reg;
                        tgt_clear_reg <= 1'b0;
                        state_reg     <= ST_WRITE;
                    end
                    else if (free_found_reg)
                    begin
                        tgt_idx_reg   <= free_idx_reg;
                        tgt_clear_reg <= 1'b1;
                        state_reg     <= ST_WRITE;
                    end
                    else
                    begin
                        evict_cnt_reg <= '0;
                        state_reg     <= ST_EVICT;
                    end
                end

                // round-robin walk, skipping entries whose key is bound
                ST_EVICT:
                begin
                    evict_ptr_reg <= (evict_ptr_reg == LAST_IDX) ? '0 : evict_ptr_reg + 1'b1;
                    if (!scan_res.bound)
                    begin
                        tgt_idx_reg   <= evict_ptr_reg;
                        tgt_clear_reg <= 1'b1;
                        state_reg     <= ST_WRITE;
                    end
                    else if (evict_cnt_reg == LAST_IDX)
                    begin
                        res_status_reg <= ktrr_pkg::STATUS_FULL;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        evict_cnt_reg <= evict_cnt_reg + 1'b1;
                    end
                end

                ST_WRITE:
                begin
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_rank_reg, res_rating_reg};
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `KTRR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `KTRR_ASSERT_IMPLY(a_write_usable_key, wr_req.en, ktrr_pkg::key_usable(target_key_reg))
    `KTRR_ASSERT_IMPLY(a_no_result_overwrite, out_load, !m_tvalid || m_tready)

endmodule

FILE: rtl/ktrr_entry_store.sv
module ktrr_entry_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ktrr_pkg::wr_req_t          wr,
    input  logic [ktrr_pkg::IDX_W-1:0] rd_idx,
    output ktrr_pkg::entry_t           rd_entry
);

    logic [ktrr_pkg::KEY_W-1:0]    key_reg    [ktrr_pkg::ENTRIES];
    logic [ktrr_pkg::RATING_W-1:0] rating_a_reg [ktrr_pkg::ENTRIES];
    logic [ktrr_pkg::RATING_W-1:0] rating_b_reg [ktrr_pkg::ENTRIES];
    logic [ktrr_pkg::RANK_W-1:0]   rank_reg   [ktrr_pkg::ENTRIES];
    logic [ktrr_pkg::ENTRIES-1:0]  valid_reg;

    // Valid flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    // Entry payload; a newly claimed entry gets the key and selected field, other fields zero
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.clear)
            begin
                key_reg[wr.idx]      <= wr.key;
                rating_a_reg[wr.idx] <= (wr.sel == ktrr_pkg::SEL_A) ? wr.rating : '0;
                rating_b_reg[wr.idx] <= (wr.sel == ktrr_pkg::SEL_B) ? wr.rating : '0;
                rank_reg[wr.idx]     <= (wr.sel == ktrr_pkg::SEL_RANK) ? wr.rank : '0;
            end
            else
            begin
                unique case (wr.sel)
                    ktrr_pkg::SEL_A:    rating_a_reg[wr.idx] <= wr.rating;
                    ktrr_pkg::SEL_B:    rating_b_reg[wr.idx] <= wr.rating;
                    ktrr_pkg::SEL_RANK: rank_reg[wr.idx]     <= wr.rank;
                    default: ;
                endcase
            end
        end
    end

    // Read port at the scan index or eviction pointer
    always_comb
    begin
        rd_entry.key      = key_reg[rd_idx];
        rd_entry.has_data = valid_reg[rd_idx];
        rd_entry.rating_a = rating_a_reg[rd_idx];
        rd_entry.rating_b = rating_b_reg[rd_idx];
        rd_entry.rank     = rank_reg[rd_idx];
    end

endmodule

FILE: rtl/ktrr_scan_unit.sv
module ktrr_scan_unit (
    input  ktrr_pkg::entry_t                                  entry,
    input  logic [ktrr_pkg::KEY_W-1:0]                        target_key,
    input  logic [ktrr_pkg::SLOTS-1:0][ktrr_pkg::KEY_W-1:0]   bound_key,
    output ktrr_pkg::scan_res_t                               res
);

    logic [ktrr_pkg::SLOTS-1:0] slot_match;

    // Entry key against every binding
    always_comb
    begin
        for (int s = 0; s < ktrr_pkg::SLOTS; s++)
        begin
            slot_match[s] = (bound_key[s] == entry.key);
        end
    end

    assign res.hit   = entry.has_data && (entry.key == target_key);
    assign res.free  = !entry.has_data;
    assign res.bound = |slot_match;

endmodule
